### rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int DATA_W      = 32;

   typedef enum logic {
      KIND_PUSH = 1'b0,
      KIND_POP  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_VAL  = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_POP_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic                     kind;
      logic signed [DATA_W-1:0] value;
   } spq_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] popped_value;
      logic signed [DATA_W-1:0] head_value;
      logic [4:0]               entry_count;
      logic                     is_empty;
      logic [1:0]               status;
   } spq_rsp_type;

   // Broadcast to every cell in a cycle
   typedef struct packed {
      logic                     push;
      logic                     pop;
      logic signed [DATA_W-1:0] value;
   } spq_cmd_type;

   // What a cell shows to its neighbors
   typedef struct packed {
      logic signed [DATA_W-1:0] entry;
      logic                     occ;
      logic                     keep;
   } spq_link_type;

endpackage

### rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell
   import spq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  spq_cmd_type  cmd,
   input  spq_link_type left_link,
   input  spq_link_type right_link,
   output spq_link_type own_link
);

   logic signed [DATA_W-1:0] entry_ff, entry_in;
   logic                     occ_ff, occ_in;
   logic                     keep;

   // An occupied entry stays put on a push if it is at least the new value
   assign keep = occ_ff && (entry_ff >= cmd.value);

   always_comb begin
      entry_in = entry_ff;
      occ_in   = occ_ff;
      if (cmd.push) begin
         if (!keep) begin
            entry_in = left_link.keep ? cmd.value : left_link.entry;
         end
         occ_in = occ_ff | left_link.occ;
      end else if (cmd.pop) begin
         entry_in = right_link.entry;
         occ_in   = right_link.occ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         occ_ff   <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         occ_ff   <= occ_in;
      end
   end

   assign own_link.entry = entry_ff;
   assign own_link.occ   = occ_ff;
   assign own_link.keep  = keep;

endmodule

### rtl/sorted_array_priority_queue_core.sv
`timescale 1ns / 1ps
// Max-priority queue of signed 32-bit values held as a sorted row of cells.
// Request channel (req_valid/req_ready/req_data): kind selects push or pop,
// value is the number to push. Response channel (rsp_valid/rsp_ready/
// rsp_data): one response per request with popped value, head after the
// operation, entry count, empty flag and status.
// Latency: the response is valid on the cycle after the request transaction.
// Throughput: one request per cycle unless a response is stalled; every cell
// compares to the broadcast value and all shift at once, so depth adds no cycles.
// A zero push or a push into a full queue is rejected and leaves the queue
// as it was; a pop of an empty queue returns zero with its own status.
// Reset (synchronous, active high) clears every cell and the count, and
// drops any pending response. When the receiver stalls, the response
// register holds and req_ready goes low until the response is taken.
// Equal values leave in arrival order.

module sorted_array_priority_queue_core
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  spq_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output spq_rsp_type rsp_data
);

   localparam spq_link_type HEAD_LINK = '{entry: '0, occ: 1'b1, keep: 1'b1};
   localparam spq_link_type TAIL_LINK = '{entry: '0, occ: 1'b0, keep: 1'b0};

   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   spq_rsp_type          rsp_ff, rsp_in;
   logic                 accept;
   spq_cmd_type          cmd;
   status_type           status;
   logic signed [DATA_W-1:0] head_next;
   logic [COUNT_W+4:0]   count_wide;

   spq_link_type cell_link  [QUEUE_DEPTH];
   spq_link_type left_link  [QUEUE_DEPTH];
   spq_link_type right_link [QUEUE_DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.push  = 1'b0;
      cmd.pop   = 1'b0;
      cmd.value = req_data.value;
      status    = STATUS_OK;
      if (req_data.kind == KIND_PUSH) begin
         if (req_data.value == '0) begin
            status = STATUS_ZERO_VAL;
         end else if (count_ff >= COUNT_W'(QUEUE_DEPTH)) begin
            status = STATUS_FULL;
         end else begin
            cmd.push = accept;
         end
      end else begin
         if (count_ff == '0) begin
            status = STATUS_POP_EMPTY;
         end else begin
            cmd.pop = accept;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         left_link[i]  = (i == 0) ? HEAD_LINK : cell_link[(i == 0) ? 0 : i - 1];
         right_link[i] = (i == QUEUE_DEPTH - 1) ? TAIL_LINK
                       : cell_link[(i == QUEUE_DEPTH - 1) ? i : i + 1];
      end
   end

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_link  (left_link[g]),
         .right_link (right_link[g]),
         .own_link   (cell_link[g])
      );
   end

   // Head after the operation; free cells hold zero so an empty queue reads zero
   always_comb begin
      count_in  = count_ff;
      head_next = cell_link[0].entry;
      if (cmd.push) begin
         count_in  = count_ff + COUNT_W'(1);
         head_next = cell_link[0].keep ? cell_link[0].entry : req_data.value;
      end else if (cmd.pop) begin
         count_in  = count_ff - COUNT_W'(1);
         head_next = cell_link[1].entry;
      end
   end

   assign count_wide = {5'd0, count_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (accept) begin
         rsp_valid_in        = 1'b1;
         rsp_in.popped_value = cmd.pop ? cell_link[0].entry : '0;
         rsp_in.head_value   = head_next;
         rsp_in.entry_count  = count_wide[4:0];
         rsp_in.is_empty     = (count_in == '0);
         rsp_in.status       = status;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import spq_pkg::*;

   localparam int CLK_PERIOD  = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RAND_ITEMS  = 700;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   spq_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   spq_rsp_type rsp_data;

   sorted_array_priority_queue_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // mirror of the queue contents, descending
   logic signed [DATA_W-1:0] model_entries [QUEUE_DEPTH];
   int                       model_count;

   spq_req_type req_backlog [$];
   spq_rsp_type expected_rsp_q [$];

   logic req_taken = 1'b0;
   int   fail_count = 0;
   int   cycle_count = 0;
   int   rsp_seen = 0;
   int   push_seen = 0;
   int   pop_seen = 0;
   int   status_seen [4] = '{0, 0, 0, 0};
   int   deepest = 0;

   bit   send_idle_on = 1'b1;
   int   send_gap = 0;
   bit   recv_idle_on = 1'b1;
   int   recv_stall = 0;
   bit   long_hold_done = 1'b0;

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic spq_rsp_type apply_queue_op(spq_req_type r);
      spq_rsp_type o;
      int          pos;
      o = '0;
      o.status = STATUS_OK;
      if (kind_type'(r.kind) == KIND_PUSH) begin
         if (r.value == 0) begin
            o.status = STATUS_ZERO_VAL;
         end else if (model_count >= QUEUE_DEPTH) begin
            o.status = STATUS_FULL;
         end else begin
            // new value goes behind every entry >= it, so ties stay FIFO
            pos = 0;
            while (pos < model_count && model_entries[pos] >= r.value) pos++;
            for (int k = model_count; k > pos; k--) model_entries[k] = model_entries[k-1];
            model_entries[pos] = r.value;
            model_count++;
         end
      end else begin
         if (model_count == 0) begin
            o.status = STATUS_POP_EMPTY;
         end else begin
            o.popped_value = model_entries[0];
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) model_entries[k] = model_entries[k+1];
            model_entries[QUEUE_DEPTH-1] = '0;
            model_count--;
         end
      end
      o.head_value  = (model_count != 0) ? model_entries[0] : '0;
      o.entry_count = model_count[4:0];
      o.is_empty    = (model_count == 0);
      return o;
   endfunction

   task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d (0x%08h), got %0d (0x%08h)", name,
                $signed(exp_v), exp_v, $signed(act_v), act_v);
         fail_count++;
      end
   endtask

   task automatic add_req(kind_type k, int v);
      spq_req_type r;
      r.kind  = k;
      r.value = v;
      req_backlog.push_back(r);
   endtask

   function automatic int pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'h7fffffff;
         1:       return 32'h80000000;
         2:       return 0;
         3, 4:    return int'($urandom_range(0, 16)) - 8;
         5:       return int'($urandom_range(0, 3)) + 32'h7ffffffc;
         default: return $urandom;
      endcase
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // monitor: scoreboard on response transactions, prediction on requests
   always @(posedge clock) begin : monitor
      spq_rsp_type exp_rsp;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (expected_rsp_q.size() == 0) begin
               $error("response transaction with nothing outstanding");
               fail_count++;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               check_field("popped_value", exp_rsp.popped_value, rsp_data.popped_value);
               check_field("head_value", exp_rsp.head_value, rsp_data.head_value);
               check_field("entry_count", exp_rsp.entry_count, rsp_data.entry_count);
               check_field("is_empty", exp_rsp.is_empty, rsp_data.is_empty);
               check_field("status", exp_rsp.status, rsp_data.status);
            end
         end
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            exp_rsp = apply_queue_op(req_data);
            expected_rsp_q.push_back(exp_rsp);
            if (kind_type'(req_data.kind) == KIND_PUSH) push_seen++;
            else pop_seen++;
            status_seen[exp_rsp.status]++;
            if (model_count > deepest) deepest = model_count;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            req_data  <= req_backlog.pop_front();
            req_valid <= 1'b1;
            if (send_idle_on && $urandom_range(0, 2) == 0) send_gap = gap_len();
            if ($urandom_range(0, 39) == 0) send_idle_on = !send_idle_on;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && rsp_seen >= 150) begin
         // long back-pressure so the core stalls its request side
         long_hold_done = 1'b1;
         recv_stall = 300;
         rsp_ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_ready <= 1'b0;
      end else if (!recv_idle_on || $urandom_range(0, 9) < 7) begin
         rsp_ready <= 1'b1;
      end else begin
         recv_stall = gap_len() - 1;
         rsp_ready <= 1'b0;
      end
      if ($urandom_range(0, 199) == 0) recv_idle_on = !recv_idle_on;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles", CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int       n;
      int       mode;
      int       len;
      int       pop_pct;
      kind_type k;

      foreach (model_entries[i]) model_entries[i] = '0;
      model_count = 0;

      // directed: empty pop, zero push, extremes, ties, fill to full
      add_req(KIND_POP, 0);
      add_req(KIND_PUSH, 0);
      add_req(KIND_PUSH, 32'h7fffffff);
      add_req(KIND_PUSH, 32'h80000000);
      add_req(KIND_PUSH, -1);
      add_req(KIND_PUSH, 1);
      add_req(KIND_PUSH, 5);
      add_req(KIND_POP, 32'hffffffff);
      add_req(KIND_PUSH, 5);
      add_req(KIND_PUSH, 5);
      for (int i = 0; i < 9; i++) add_req(KIND_PUSH, pick_value() | 1);
      add_req(KIND_PUSH, 3);
      add_req(KIND_PUSH, 0);
      add_req(KIND_POP, 0);
      add_req(KIND_POP, 0);

      n = 0;
      while (n < RAND_ITEMS) begin
         mode = $urandom_range(0, 9);
         len  = $urandom_range(4, 24);
         if (mode < 4) pop_pct = 15;        // fill up
         else if (mode < 7) pop_pct = 80;   // drain
         else pop_pct = 50;
         for (int i = 0; i < len; i++) begin
            k = ($urandom_range(0, 99) < pop_pct) ? KIND_POP : KIND_PUSH;
            add_req(k, (k == KIND_POP && mode != 9) ? 0 : pick_value());
            n++;
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (req_backlog.size() != 0 || req_valid || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (expected_rsp_q.size() != 0) begin
         $error("%0d responses never arrived", expected_rsp_q.size());
         fail_count++;
      end
      $display("Ran %0d pushes and %0d pops over %0d cycles, deepest fill %0d of %0d",
               push_seen, pop_seen, cycle_count, deepest, QUEUE_DEPTH);
      $display("Status mix: ok %0d, zero rejected %0d, full %0d, empty pop %0d",
               status_seen[STATUS_OK], status_seen[STATUS_ZERO_VAL],
               status_seen[STATUS_FULL], status_seen[STATUS_POP_EMPTY]);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### sorted_array_priority_queue_core.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_array_priority_queue_core.sv
verif/testbench.sv
